// ----- hw/rtl/vsb_pkg.sv -----
// Shared widths, register indexes and pipeline types for the sphere brush.
`default_nettype none
package vsb_pkg;

  localparam int COORD_W    = 8;
  localparam int FRAC_BITS  = 8;
  localparam int FIX_W      = COORD_W + FRAC_BITS;
  localparam int DENS_W     = 8;
  localparam int SQ_W       = 2 * FIX_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int REM_W      = ROOT_W + 3;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int IDX_W      = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_RADIUS   = 3'd3,
    REG_FILL     = 3'd4
  } reg_index_t;

  // One sqrt digit stage: remaining radicand bits, partial remainder, root and the carried density.
  typedef struct packed {
    logic [SUM_W-1:0]  bits;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [DENS_W-1:0] old_density;
  } sqrt_data_t;

endpackage
`default_nettype wire

// ----- hw/rtl/vsb_dist_sq.sv -----
// Three-stage squared distance: absolute deltas, squares, sum.
`default_nettype none
module vsb_dist_sq
  import vsb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [COORD_W-1:0] voxel_x,
  input  wire logic [COORD_W-1:0] voxel_y,
  input  wire logic [COORD_W-1:0] voxel_z,
  input  wire logic [DENS_W-1:0] old_density,
  input  wire logic [FIX_W-1:0]  center_x,
  input  wire logic [FIX_W-1:0]  center_y,
  input  wire logic [FIX_W-1:0]  center_z,
  output logic                   out_valid,
  output logic [SUM_W-1:0]       sum,
  output logic [DENS_W-1:0]      out_density
);

  logic [FIX_W-1:0]  px, py, pz;
  logic [FIX_W-1:0]  dx, dy, dz;
  logic [SQ_W-1:0]   sqx, sqy, sqz;
  logic [DENS_W-1:0] dens1, dens2;
  logic              valid1, valid2;

  assign px = {voxel_x, {FRAC_BITS{1'b0}}};
  assign py = {voxel_y, {FRAC_BITS{1'b0}}};
  assign pz = {voxel_z, {FRAC_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1    <= 1'b0;
      valid2    <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid1    <= in_valid;
      valid2    <= valid1;
      out_valid <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx    <= (px >= center_x) ? (px - center_x) : (center_x - px);
      dy    <= (py >= center_y) ? (py - center_y) : (center_y - py);
      dz    <= (pz >= center_z) ? (pz - center_z) : (center_z - pz);
      dens1 <= old_density;
      sqx   <= dx * dx;
      sqy   <= dy * dy;
      sqz   <= dz * dz;
      dens2 <= dens1;
      sum   <= {2'b00, sqx} + {2'b00, sqy} + {2'b00, sqz};
      out_density <= dens2;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/vsb_sqrt_stage.sv -----
// One registered digit of the restoring integer square root.
`default_nettype none
module vsb_sqrt_stage
  import vsb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       en,
  input  wire logic       in_valid,
  input  wire sqrt_data_t in_data,
  output logic            out_valid,
  output sqrt_data_t      out_data
);

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  sqrt_data_t       data_next;

  always_comb begin
    rem_sh    = {in_data.rem[REM_W-3:0], in_data.bits[SUM_W-1 -: 2]};
    trial     = {1'b0, in_data.root, 2'b01};
    data_next = in_data;
    data_next.bits = {in_data.bits[SUM_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      data_next.rem  = rem_sh - trial;
      data_next.root = {in_data.root[ROOT_W-2:0], 1'b1};
    end else begin
      data_next.rem  = rem_sh;
      data_next.root = {in_data.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/vsb_shade.sv -----
// Final stage: shell test, weight times 255 and fill/carve blend, registered.
`default_nettype none
module vsb_shade
  import vsb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [ROOT_W-1:0] distance,
  input  wire logic [DENS_W-1:0] old_density,
  input  wire logic [FIX_W-1:0]  radius,
  input  wire logic              fill_mode,
  output logic                   out_valid,
  output logic [DENS_W-1:0]      new_density,
  output logic                   touched
);

  localparam int WIDE_W = ROOT_W + 1;
  localparam int N_W    = FRAC_BITS + 2;
  localparam int PROD_W = N_W + DENS_W;

  localparam logic [WIDE_W-1:0] ONE_W = WIDE_W'(1) << FRAC_BITS;
  localparam logic [N_W-1:0]    TWO_N = N_W'(1) << (FRAC_BITS + 1);

  logic [WIDE_W-1:0] dist_w, rad_w, dist_p1, rad_p1, n_full;
  logic [N_W-1:0]    n, w_num;
  logic [PROD_W-1:0] prod;
  logic [DENS_W-1:0] val, res;
  logic              hit;

  always_comb begin
    dist_w  = {1'b0, distance};
    rad_w   = {{(WIDE_W-FIX_W){1'b0}}, radius};
    dist_p1 = dist_w + ONE_W;
    rad_p1  = rad_w + ONE_W;
    hit     = (dist_w <= rad_p1);
    n_full  = (dist_p1 >= rad_w) ? (dist_p1 - rad_w) : '0;
    // inside the shell n never exceeds two
    n       = n_full[N_W-1:0];
    w_num   = fill_mode ? (TWO_N - n) : n;
    prod    = {w_num, {DENS_W{1'b0}}} - {{DENS_W{1'b0}}, w_num};
    val     = prod[FRAC_BITS+1 +: DENS_W];
    if (!hit) begin
      res = old_density;
    end else if (fill_mode) begin
      res = (val > old_density) ? val : old_density;
    end else begin
      res = (val < old_density) ? val : old_density;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      new_density <= res;
      touched     <= hit;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/voxel_sphere_brush.sv -----
// Spherical density brush: edits one voxel density per beat.
// Usage:
//   Input channel (in_valid/in_ready) carries voxel_x/y/z and old_density.
//   Output channel (out_valid/out_ready) carries new_density and touched.
//   Configuration: pulse cfg_write with cfg_index (0 center_x, 1 center_y,
//   2 center_z, 3 radius, 4 fill_mode) and cfg_data; write only while idle.
// Pipeline from input beat to output beat: 3 distance stages,
//   17 square-root digit stages, 1 blend/output stage.
// Throughput: one beat per cycle unless stalled; every stage is a register
//   stage and the sqrt has one digit stage per result bit.
// Reset: clears all pipeline valid bits and the configuration registers
//   (center at origin, radius 0, carve mode).
// Stall: when out_ready is low with a result waiting, the whole pipeline
//   freezes and in_ready drops; bubbles in the pipe stay where they are
//   and are not squeezed out. Nothing is dropped or repeated.
`default_nettype none
module voxel_sphere_brush
  import vsb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [COORD_W-1:0] voxel_x,
  input  wire logic [COORD_W-1:0] voxel_y,
  input  wire logic [COORD_W-1:0] voxel_z,
  input  wire logic [DENS_W-1:0] old_density,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [DENS_W-1:0]      new_density,
  output logic                   touched,
  input  wire logic              cfg_write,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [FIX_W-1:0]  cfg_data
);

  logic [FIX_W-1:0] center_x, center_y, center_z, radius;
  logic             fill_mode;
  logic             en;

  logic              ds_valid;
  logic [SUM_W-1:0]  ds_sum;
  logic [DENS_W-1:0] ds_density;

  logic       sv [0:SQRT_STEPS];
  sqrt_data_t sd [0:SQRT_STEPS];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x  <= '0;
      center_y  <= '0;
      center_z  <= '0;
      radius    <= '0;
      fill_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CENTER_X: center_x  <= cfg_data;
        REG_CENTER_Y: center_y  <= cfg_data;
        REG_CENTER_Z: center_z  <= cfg_data;
        REG_RADIUS:   radius    <= cfg_data;
        REG_FILL:     fill_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  vsb_dist_sq u_dist (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (in_valid),
    .voxel_x     (voxel_x),
    .voxel_y     (voxel_y),
    .voxel_z     (voxel_z),
    .old_density (old_density),
    .center_x    (center_x),
    .center_y    (center_y),
    .center_z    (center_z),
    .out_valid   (ds_valid),
    .sum         (ds_sum),
    .out_density (ds_density)
  );

  always_comb begin
    sv[0]             = ds_valid;
    sd[0].bits        = ds_sum;
    sd[0].rem         = '0;
    sd[0].root        = '0;
    sd[0].old_density = ds_density;
  end

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    vsb_sqrt_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (sv[i]),
      .in_data   (sd[i]),
      .out_valid (sv[i+1]),
      .out_data  (sd[i+1])
    );
  end

  vsb_shade u_shade (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (sv[SQRT_STEPS]),
    .distance    (sd[SQRT_STEPS].root),
    .old_density (sd[SQRT_STEPS].old_density),
    .radius      (radius),
    .fill_mode   (fill_mode),
    .out_valid   (out_valid),
    .new_density (new_density),
    .touched     (touched)
  );

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the voxel sphere brush: driver, monitor and edit predictor.
`default_nettype none
module tb
  import vsb_pkg::*;
();

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RAND_ITEMS   = 200;
  localparam int N_PHASES     = 8;
  localparam longint unsigned ONE = 64'd1 << FRAC_BITS;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [DENS_W-1:0]  density;
  } voxel_t;

  typedef struct packed {
    logic [DENS_W-1:0] density;
    logic              hit;
  } edit_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [COORD_W-1:0] voxel_x = '0;
  logic [COORD_W-1:0] voxel_y = '0;
  logic [COORD_W-1:0] voxel_z = '0;
  logic [DENS_W-1:0]  old_density = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [DENS_W-1:0]  new_density;
  logic               touched;
  logic               cfg_write = 1'b0;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [FIX_W-1:0]   cfg_data = '0;

  // brush settings as the block should hold them
  logic [FIX_W-1:0] brush_cx = '0;
  logic [FIX_W-1:0] brush_cy = '0;
  logic [FIX_W-1:0] brush_cz = '0;
  logic [FIX_W-1:0] brush_r  = '0;
  logic             brush_fill = 1'b0;

  voxel_t pending_voxels[$];
  edit_t  expected_edits[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_done;
  int hold_cnt;
  int cycle_cnt = 0;
  int err_cnt = 0;
  int n_checked = 0;
  int n_touched = 0;
  int n_settings = 0;

  voxel_sphere_brush u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .voxel_x     (voxel_x),
    .voxel_y     (voxel_y),
    .voxel_z     (voxel_z),
    .old_density (old_density),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .new_density (new_density),
    .touched     (touched),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned axis_sq(input logic [COORD_W-1:0] v,
                                              input logic [FIX_W-1:0] c);
    longint unsigned p, d;
    p = 64'(v);
    p = p << FRAC_BITS;
    d = (p >= c) ? p - c : c - p;
    return d * d;
  endfunction

  function automatic edit_t predict_edit(input voxel_t vox);
    longint unsigned sq, root, trial, n, val;
    edit_t e;
    sq = axis_sq(vox.x, brush_cx) + axis_sq(vox.y, brush_cy) + axis_sq(vox.z, brush_cz);
    root = 0;
    // floor sqrt, one result bit at a time from the top
    for (int b = ROOT_W; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= sq) root = trial;
    end
    e.density = vox.density;
    e.hit = 1'b0;
    if (root <= brush_r + ONE) begin
      e.hit = 1'b1;
      n = (root + ONE >= brush_r) ? root + ONE - brush_r : 0;
      if (brush_fill) begin
        val = ((2 * ONE - n) * 255) >> (FRAC_BITS + 1);
        if (val > vox.density) e.density = DENS_W'(val);
      end else begin
        val = (n * 255) >> (FRAC_BITS + 1);
        if (val < vox.density) e.density = DENS_W'(val);
      end
    end
    return e;
  endfunction

  // input side: present the next pending voxel once the previous beat is taken
  always @(posedge clk) begin : drive_voxels
    voxel_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_edits.push_back(predict_edit({voxel_x, voxel_y, voxel_z, old_density}));
      if (!in_valid || in_ready) begin
        if (pending_voxels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_voxels.pop_front();
          in_valid    <= 1'b1;
          voxel_x     <= nxt.x;
          voxel_y     <= nxt.y;
          voxel_z     <= nxt.z;
          old_density <= nxt.density;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_cnt  <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_edits
    edit_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_edits.size() == 0) begin
        $error("output beat with no voxel outstanding: new_density=%0d touched=%0d",
               new_density, touched);
        err_cnt++;
      end else begin
        want = expected_edits.pop_front();
        n_checked++;
        if (want.hit) n_touched++;
        if (new_density !== want.density) begin
          $error("new_density: expected %0d, actual %0d", want.density, new_density);
          err_cnt++;
        end
        if (touched !== want.hit) begin
          $error("touched: expected %0d, actual %0d", want.hit, touched);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d edits outstanding",
               cycle_cnt, expected_edits.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [FIX_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_CENTER_X: brush_cx = val;
      REG_CENTER_Y: brush_cy = val;
      REG_CENTER_Z: brush_cz = val;
      REG_RADIUS:   brush_r = val;
      REG_FILL:     brush_fill = val[0];
      default: ;
    endcase
  endtask

  task automatic set_brush(input logic [FIX_W-1:0] cx, cy, cz, r, input logic fill);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_RADIUS, r);
    // upper bits of the mode word are don't-care
    write_reg(REG_FILL, {(FIX_W-1)'($urandom), fill});
    @(posedge clk);
    cfg_write <= 1'b0;
    n_settings++;
  endtask

  task automatic queue_voxel(input int x, y, z, od);
    voxel_t v;
    v.x = COORD_W'(x);
    v.y = COORD_W'(y);
    v.z = COORD_W'(z);
    v.density = DENS_W'(od);
    pending_voxels.push_back(v);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_voxels.size() != 0 || in_valid || expected_edits.size() != 0)
      @(negedge clk);
  endtask

  function automatic logic [COORD_W-1:0] near_coord(input logic [FIX_W-1:0] c,
                                                    input logic [FIX_W-1:0] r);
    int span, v;
    span = int'(r >> FRAC_BITS) + 3;
    v = int'(c >> FRAC_BITS) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > (1 << COORD_W) - 1) v = (1 << COORD_W) - 1;
    return COORD_W'(v);
  endfunction

  task automatic queue_random(input int count);
    int od;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(7))
        0: od = 0;
        1: od = 255;
        default: od = $urandom_range(255);
      endcase
      if ($urandom_range(3) == 0)
        queue_voxel($urandom_range(255), $urandom_range(255), $urandom_range(255), od);
      else
        queue_voxel(int'(near_coord(brush_cx, brush_r)), int'(near_coord(brush_cy, brush_r)),
                    int'(near_coord(brush_cz, brush_r)), od);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: origin, radius zero, carve
    @(negedge clk);
    queue_voxel(0, 0, 0, 255);
    queue_voxel(0, 0, 0, 0);
    queue_voxel(1, 0, 0, 200);
    queue_voxel(0, 0, 2, 255);
    queue_voxel(255, 255, 255, 255);
    wait_drained();

    // fill around a half-voxel centre: inside, shell, edge of reach, outside
    set_brush(16'h6480, 16'h6480, 16'h6480, 16'h0A00, 1'b1);
    @(negedge clk);
    queue_voxel(100, 100, 100, 0);
    queue_voxel(110, 100, 100, 0);
    queue_voxel(110, 100, 100, 255);
    queue_voxel(111, 100, 100, 17);
    queue_voxel(112, 100, 100, 17);
    queue_voxel(91, 100, 100, 128);
    queue_voxel(100, 89, 100, 3);
    wait_drained();

    // radius below one, carve
    set_brush(16'h0A00, 16'h0A00, 16'h0A00, 16'h0080, 1'b0);
    @(negedge clk);
    queue_voxel(10, 10, 10, 255);
    queue_voxel(11, 10, 10, 255);
    queue_voxel(10, 11, 11, 255);
    queue_voxel(12, 10, 10, 90);
    wait_drained();

    // largest centre and radius
    set_brush(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    @(negedge clk);
    queue_voxel(255, 255, 255, 0);
    queue_voxel(0, 0, 0, 0);
    queue_voxel(255, 0, 255, 40);
    queue_voxel(128, 128, 128, 255);
    queue_voxel(0, 255, 0, 0);
    wait_drained();

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: set_brush(FIX_W'($urandom), FIX_W'($urandom), FIX_W'($urandom),
                     FIX_W'($urandom_range(16'h2000)), 1'($urandom_range(1)));
        1: set_brush('0, '0, '0, '0, 1'b0);
        2: set_brush(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        3: set_brush(FIX_W'($urandom), FIX_W'($urandom), FIX_W'($urandom),
                     FIX_W'($urandom_range(16'h00FF)), 1'b0);
        4: set_brush(FIX_W'($urandom), FIX_W'($urandom), FIX_W'($urandom),
                     FIX_W'($urandom_range(16'h4000)), 1'b1);
        5: set_brush(FIX_W'($urandom), FIX_W'($urandom), FIX_W'($urandom),
                     16'hFFFF, 1'b0);
        6: set_brush(FIX_W'($urandom), FIX_W'($urandom), FIX_W'($urandom),
                     16'h0100, 1'($urandom_range(1)));
        default: set_brush(FIX_W'($urandom), FIX_W'($urandom), FIX_W'($urandom),
                           FIX_W'($urandom), 1'($urandom_range(1)));
      endcase
      case (p % 4)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 63; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 63; end
        default: begin send_idle_pct <= 33; recv_stall_pct <= 33; end
      endcase
      @(negedge clk);
      queue_random(RAND_ITEMS);
      // long output hold-off with the input still streaming: pipe fills, in_ready drops
      if (p == 4) hold_req <= 1'b1;
      wait_drained();
    end

    repeat (30) @(posedge clk);
    $display("checked %0d voxel edits over %0d brush settings, %0d inside the brush reach",
             n_checked, n_settings, n_touched);
    $display("fill and carve, sub-voxel and full-range radius, with input/output idling");
    if (err_cnt == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire
